// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

  // result kind codes
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_FRAME = 2'd0;
  localparam kind_t KIND_DATA  = 2'd1;
  localparam kind_t KIND_DONE  = 2'd2;
  localparam kind_t KIND_ERR   = 2'd3;

  typedef logic [7:0] byte_t;

endpackage

// ===== design/http_chunked_body_decoder_core.sv =====
// channel | ports                                  | beat
// --------+----------------------------------------+-------------------------------
// in      | in_valid, in_ready, in_byte            | one raw byte of the chunked body
// out     | out_valid, out_ready, out_payload_byte,| one result per input byte
//         | out_kind                               |
//
// one byte per clock unless out_ready stalls: the parser state updates and the result
// register loads in the cycle the byte is accepted; the result shows on the next cycle
// the only loop is the parser state itself (phase, size, byte count), one step per byte
// rst_n is synchronous, active low; it returns the parser to the start of a message
// a stalled result holds in the output register; a new byte is taken in the same
// cycle the held result leaves, so out_ready low stalls the input one for one
module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbd_pkg::byte_t     in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::byte_t     out_payload_byte,
  output hcbd_pkg::kind_t     out_kind
);
  import hcbd_pkg::*;

  // parser phases
  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_EXT   = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;
  localparam logic [2:0] PH_FINAL = 3'd6;

  localparam byte_t CH_CR   = 8'h0d;
  localparam byte_t CH_LF   = 8'h0a;
  localparam byte_t CH_SEMI = 8'h3b;

  localparam logic [1:0] SKIP_LEN = 2'd2;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] size_accum_r, size_accum_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                 digit_seen_r, digit_seen_nxt;
  logic [1:0]           skip_count_r, skip_count_nxt;
  logic                 line_start_r, line_start_nxt;

  logic                 out_valid_r;
  byte_t                out_payload_r, out_payload_nxt;
  kind_t                out_kind_r, out_kind_nxt;

  logic                 accept;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic                 is_cr, is_lf, is_semi;
  logic                 size_full;
  logic [SIZE_BITS-1:0] left_dec;
  logic [1:0]           skip_dec;

  // output register frees itself in the same cycle its beat is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_r;
  assign out_kind         = out_kind_r;

  // hex digit decode, both cases
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_cr   = (in_byte == CH_CR);
  assign is_lf   = (in_byte == CH_LF);
  assign is_semi = (in_byte == CH_SEMI);

  // another digit would shift a nonzero nibble out of the top
  assign size_full = (size_accum_r[SIZE_BITS-1 -: 4] != 4'd0);

  assign left_dec = (bytes_left_r != '0) ? bytes_left_r - 1'b1 : '0;
  assign skip_dec = (skip_count_r != 2'd0) ? skip_count_r - 2'd1 : 2'd0;

  always_comb begin
    phase_nxt       = phase_r;
    size_accum_nxt  = size_accum_r;
    bytes_left_nxt  = bytes_left_r;
    digit_seen_nxt  = digit_seen_r;
    skip_count_nxt  = skip_count_r;
    line_start_nxt  = line_start_r;
    out_payload_nxt = '0;
    out_kind_nxt    = KIND_FRAME;

    unique case (phase_r)
      PH_SIZE: begin
        if (is_hex) begin
          if (size_full) begin
            phase_nxt    = PH_ERR;
            out_kind_nxt = KIND_ERR;
          end else begin
            size_accum_nxt = {size_accum_r[SIZE_BITS-5:0], hex_val};
            digit_seen_nxt = 1'b1;
          end
        end else if (!digit_seen_r || !(is_cr || is_lf || is_semi)) begin
          // empty size or a stray character in the size
          phase_nxt    = PH_ERR;
          out_kind_nxt = KIND_ERR;
        end else if (is_lf) begin
          if (size_accum_r == '0) begin
            phase_nxt      = PH_TRAIL;
            line_start_nxt = 1'b1;
          end else begin
            phase_nxt      = PH_DATA;
            bytes_left_nxt = size_accum_r;
          end
        end else begin
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        if (is_lf) begin
          if (size_accum_r == '0) begin
            phase_nxt      = PH_TRAIL;
            line_start_nxt = 1'b1;
          end else begin
            phase_nxt      = PH_DATA;
            bytes_left_nxt = size_accum_r;
          end
        end
      end
      PH_DATA: begin
        out_kind_nxt    = KIND_DATA;
        out_payload_nxt = in_byte;
        bytes_left_nxt  = left_dec;
        if (left_dec == '0) begin
          phase_nxt      = PH_SKIP;
          skip_count_nxt = SKIP_LEN;
        end
      end
      PH_SKIP: begin
        // chunk trailing CRLF, not checked
        skip_count_nxt = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_nxt      = PH_SIZE;
          size_accum_nxt = '0;
          digit_seen_nxt = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (line_start_r && is_lf) begin
          phase_nxt      = PH_SIZE;
          size_accum_nxt = '0;
          bytes_left_nxt = '0;
          digit_seen_nxt = 1'b0;
          skip_count_nxt = 2'd0;
          line_start_nxt = 1'b1;
          out_kind_nxt   = KIND_DONE;
        end else if (line_start_r && is_cr) begin
          phase_nxt = PH_FINAL;
        end else begin
          line_start_nxt = is_lf;
        end
      end
      PH_FINAL: begin
        if (is_lf) begin
          phase_nxt      = PH_SIZE;
          size_accum_nxt = '0;
          bytes_left_nxt = '0;
          digit_seen_nxt = 1'b0;
          skip_count_nxt = 2'd0;
          line_start_nxt = 1'b1;
          out_kind_nxt   = KIND_DONE;
        end
      end
      default: begin
        // sticky error, also catches the unused phase code
        phase_nxt    = PH_ERR;
        out_kind_nxt = KIND_ERR;
      end
    endcase
  end

  // parser state and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      size_accum_r <= '0;
      bytes_left_r <= '0;
      digit_seen_r <= 1'b0;
      skip_count_r <= 2'd0;
      line_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        size_accum_r <= size_accum_nxt;
        bytes_left_r <= bytes_left_nxt;
        digit_seen_r <= digit_seen_nxt;
        skip_count_r <= skip_count_nxt;
        line_start_r <= line_start_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_payload_r <= out_payload_nxt;
      out_kind_r    <= out_kind_nxt;
    end
  end

endmodule

// ===== design/hcbd_checker.sv =====
module hcbd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input hcbd_pkg::byte_t out_payload_byte,
  input hcbd_pkg::kind_t out_kind
);
  import hcbd_pkg::*;

  logic err_seen_r;

  // an error beat has left the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_kind == KIND_ERR) begin
      err_seen_r <= 1'b1;
    end
  end

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_kind))
    else $error("result changed while stalled");

  // every accepted byte yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result");

  // only payload results carry a nonzero byte
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_payload_byte == 8'd0)
    else $error("framing result carries a byte");

  // errors are sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_kind == KIND_ERR)
    else $error("result after error is not an error");

  // ready while the output register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_payload_byte (out_payload_byte),
  .out_kind         (out_kind)
);
